// ----- rtl/core/attc_pkg.sv -----
// shared types, character codes and helpers of the ansi text terminal controller
package attc_pkg;

  // glyph cell geometry in pixels
  localparam int unsigned GLYPH_WIDTH   = 8;
  localparam int unsigned GLYPH_HEIGHT  = 16;
  localparam int unsigned GLYPH_W_SHIFT = 3;
  localparam int unsigned GLYPH_H_SHIFT = 4;

  // register widths and reset values
  localparam int unsigned DIM_W          = 13;
  localparam int unsigned POS_W          = 16;
  localparam int unsigned ATTR_W         = 18;
  localparam int unsigned ROW_W          = 5;
  localparam logic [12:0] WIDTH_RESET    = 13'd640;
  localparam logic [12:0] HEIGHT_RESET   = 13'd480;
  localparam logic [17:0] ATTR_RESET     = 18'h0000a;
  localparam logic [4:0]  CURSOR_ROWS    = 5'd16;
  localparam logic [4:0]  CURSOR_HI_DFLT = 5'd3;
  localparam logic [15:0] ARG_MAX        = 16'hffff;

  // register indexes of the config port
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // parse modes
  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_CSI  = 2'd2;

  // framebuffer command codes
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_GLYPH  = 3'd1;
  localparam logic [2:0] CMD_SCROLL = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_INSERT = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // character codes
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] FIN_M     = 8'h6d;
  localparam logic [7:0] FIN_UP    = 8'h41;
  localparam logic [7:0] FIN_DOWN  = 8'h42;
  localparam logic [7:0] FIN_RIGHT = 8'h43;
  localparam logic [7:0] FIN_LEFT  = 8'h44;
  localparam logic [7:0] FIN_INS   = 8'h61;
  localparam logic [7:0] FIN_J     = 8'h4a;
  localparam logic [7:0] FIN_K     = 8'h4b;
  localparam logic [7:0] FIN_H     = 8'h48;
  localparam logic [7:0] FIN_SAVE  = 8'h73;
  localparam logic [7:0] FIN_REST  = 8'h75;
  localparam logic [7:0] FIN_HIDE  = 8'h6c;
  localparam logic [7:0] FIN_SHAPE = 8'h68;

  // screen geometry from the config registers
  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] cmd_x;
    logic [15:0] cmd_y;
    logic [15:0] cmd_amount;
    logic [7:0]  glyph_code;
    logic [17:0] glyph_attr;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic [4:0]  cursor_top_row;
    logic [4:0]  cursor_end_row;
  } result_t;

  // sgr colour code applied to an attribute
  function automatic logic [17:0] set_colour(input logic [17:0] a, input logic [15:0] code);
    logic [17:0] r;
    logic [15:0] fg;
    logic [15:0] bg;
    fg = code - 16'd30;
    bg = code - 16'd40;
    case (code)
      16'd0:   r = 18'h00007;
      16'd1:   r = a | 18'h00008;
      16'd2:   r = a | 18'h00800;
      16'd4:   r = a | 18'h10000;
      16'd5:   r = a | 18'h20000;
      16'd7:   r = a ^ 18'h0ffff;
      16'd8:   r = a & 18'h0ffff;
      default: begin
        if (code inside {[16'd30:16'd37]}) begin
          r = {a[17:8], fg[7:0]};
        end else if (code inside {[16'd40:16'd47]}) begin
          r = {a[17:16], bg[7:0], a[7:0]};
        end else begin
          r = a;
        end
      end
    endcase
    return r;
  endfunction

  // cursor shape rows saturate at the glyph height
  function automatic logic [4:0] clamp_rows(input logic [15:0] v);
    return (v > 16'(CURSOR_ROWS)) ? CURSOR_ROWS : v[4:0];
  endfunction

endpackage

// ----- rtl/core/attc_char_if.sv -----
// character input channel
interface attc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

// ----- rtl/core/attc_cmd_if.sv -----
// framebuffer command output channel
interface attc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] cmd_x;
  logic [15:0] cmd_y;
  logic [15:0] cmd_amount;
  logic [7:0]  glyph_code;
  logic [17:0] glyph_attr;
  logic [15:0] cursor_x;
  logic [15:0] cursor_y;
  logic [4:0]  cursor_top_row;
  logic [4:0]  cursor_end_row;

  modport source (
    output valid, output command, output cmd_x, output cmd_y, output cmd_amount,
    output glyph_code, output glyph_attr, output cursor_x, output cursor_y,
    output cursor_top_row, output cursor_end_row, input ready
  );
  modport sink (
    input valid, input command, input cmd_x, input cmd_y, input cmd_amount,
    input glyph_code, input glyph_attr, input cursor_x, input cursor_y,
    input cursor_top_row, input cursor_end_row, output ready
  );
endinterface

// ----- rtl/core/attc_cfg.sv -----
// apb register file for the screen geometry
module attc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output attc_pkg::cfg_t      cfg_o
);

  logic        wr_en;
  logic        reg_sel;
  logic [12:0] width_q;
  logic [12:0] height_q;

  // word select, byte lanes ignored
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= attc_pkg::WIDTH_RESET;
      height_q <= attc_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      if (reg_sel == attc_pkg::REG_SCREEN_WIDTH) begin
        width_q <= pwdata[12:0];
      end else begin
        height_q <= pwdata[12:0];
      end
    end
  end

  // read back
  assign prdata = (reg_sel == attc_pkg::REG_SCREEN_HEIGHT) ? {19'd0, height_q}
                                                           : {19'd0, width_q};

  assign cfg_o.screen_width  = width_q;
  assign cfg_o.screen_height = height_q;

endmodule

// ----- rtl/core/attc_core.sv -----
// terminal state registers and the per-character step logic
module attc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         char_code_i,
  input  attc_pkg::cfg_t     cfg_i,
  output attc_pkg::result_t  result_o
);

  logic [15:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [15:0] saved_x_q, saved_x_d, saved_y_q, saved_y_d;
  logic [17:0] attr_q, attr_d, attr_mid;
  logic [4:0]  cur_low_q, cur_low_d, cur_high_q, cur_high_d;
  logic [1:0]  mode_q, mode_d;
  logic [15:0] arg_cur_q, arg_cur_d, arg_prev_q, arg_prev_d;

  logic [12:0] sw, sh, xmax, ymax;
  logic [15:0] n;
  logic [19:0] n_w, n_h;
  logic [15:0] line_left;
  logic [16:0] ny, ny_over;
  logic [16:0] glyph_adv;
  logic [20:0] down_v, right_v;
  logic [28:0] page_v;
  logic [19:0] digit_v;
  logic        text_en;
  logic        final_en;
  logic [2:0]  cmd;
  logic [15:0] cx, cy, camt;
  logic [7:0]  gcode;

  // derived geometry and argument scaling
  always_comb begin
    sw        = cfg_i.screen_width;
    sh        = cfg_i.screen_height;
    xmax      = (sw > 13'(attc_pkg::GLYPH_WIDTH)) ? sw - 13'(attc_pkg::GLYPH_WIDTH) : '0;
    ymax      = (sh > 13'(attc_pkg::GLYPH_HEIGHT)) ? sh - 13'(attc_pkg::GLYPH_HEIGHT) : '0;
    n         = (arg_cur_q != '0) ? arg_cur_q : 16'd1;
    n_w       = 20'(n) << attc_pkg::GLYPH_W_SHIFT;
    n_h       = 20'(n) << attc_pkg::GLYPH_H_SHIFT;
    line_left = (16'(xmax) > pos_x_q) ? 16'(xmax) - pos_x_q : '0;
    ny        = 17'(pos_y_q) + 17'(attc_pkg::GLYPH_HEIGHT);
    ny_over   = ny - 17'(ymax);
    glyph_adv = 17'(pos_x_q) + 17'(attc_pkg::GLYPH_WIDTH);
    down_v    = 21'(pos_y_q) + 21'(n_h);
    right_v   = 21'(pos_x_q) + 21'(n_w);
    page_v    = 29'(n) * 29'(ymax);
    digit_v   = ({4'd0, arg_cur_q} << 3) + ({4'd0, arg_cur_q} << 1)
              + 20'(char_code_i - attc_pkg::CH_ZERO);
  end

  // parse mode and argument collection
  always_comb begin
    mode_d     = mode_q;
    arg_cur_d  = arg_cur_q;
    arg_prev_d = arg_prev_q;
    text_en    = 1'b0;
    final_en   = 1'b0;
    case (mode_q)
      attc_pkg::MODE_CSI: begin
        if (char_code_i inside {[attc_pkg::CH_ZERO:attc_pkg::CH_NINE]}) begin
          arg_cur_d = (digit_v > 20'(attc_pkg::ARG_MAX)) ? attc_pkg::ARG_MAX : digit_v[15:0];
        end else if (char_code_i == attc_pkg::CH_SEMI) begin
          arg_prev_d = arg_cur_q;
          arg_cur_d  = '0;
        end else begin
          final_en = 1'b1;
          mode_d   = attc_pkg::MODE_TEXT;
        end
      end
      attc_pkg::MODE_ESC: begin
        if (char_code_i == attc_pkg::CH_LBRACK) begin
          mode_d     = attc_pkg::MODE_CSI;
          arg_cur_d  = '0;
          arg_prev_d = '0;
        end else if (char_code_i != attc_pkg::CH_ESC) begin
          mode_d  = attc_pkg::MODE_TEXT;
          text_en = 1'b1;
        end
      end
      default: begin
        if (char_code_i == attc_pkg::CH_ESC) begin
          mode_d = attc_pkg::MODE_ESC;
        end else begin
          mode_d  = attc_pkg::MODE_TEXT;
          text_en = 1'b1;
        end
      end
    endcase
  end

  // text bytes and final letters
  always_comb begin
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    saved_x_d  = saved_x_q;
    saved_y_d  = saved_y_q;
    attr_mid   = (arg_prev_q != '0) ? attc_pkg::set_colour(attr_q, arg_prev_q) : attr_q;
    attr_d     = attr_q;
    cur_low_d  = cur_low_q;
    cur_high_d = cur_high_q;
    cmd        = attc_pkg::CMD_NONE;
    cx         = '0;
    cy         = '0;
    camt       = '0;
    gcode      = '0;
    if (text_en) begin
      if (char_code_i == attc_pkg::CH_LF) begin
        pos_x_d = '0;
        if (ny > 17'(ymax)) begin
          cmd     = attc_pkg::CMD_SCROLL;
          camt    = (ny_over > 17'(sh)) ? 16'(sh) : ny_over[15:0];
          pos_y_d = 16'(ymax);
        end else begin
          pos_y_d = ny[15:0];
        end
      end else if (char_code_i == attc_pkg::CH_BS) begin
        if (pos_x_q >= 16'(attc_pkg::GLYPH_WIDTH)) begin
          cmd     = attc_pkg::CMD_DELETE;
          cx      = pos_x_q;
          cy      = pos_y_q;
          camt    = line_left;
          pos_x_d = pos_x_q - 16'(attc_pkg::GLYPH_WIDTH);
        end
      end else if (char_code_i inside {[attc_pkg::CH_SPACE:attc_pkg::CH_TILDE]}) begin
        cmd     = attc_pkg::CMD_GLYPH;
        cx      = pos_x_q;
        cy      = pos_y_q;
        gcode   = char_code_i;
        pos_x_d = glyph_adv[16] ? attc_pkg::ARG_MAX : glyph_adv[15:0];
      end
    end else if (final_en) begin
      case (char_code_i)
        attc_pkg::FIN_M: begin
          attr_d = attc_pkg::set_colour(attr_mid, arg_cur_q);
        end
        attc_pkg::FIN_UP: begin
          pos_y_d = (20'(pos_y_q) > n_h) ? pos_y_q - n_h[15:0] : '0;
        end
        attc_pkg::FIN_DOWN: begin
          pos_y_d = (down_v > 21'(ymax)) ? 16'(ymax) : down_v[15:0];
        end
        attc_pkg::FIN_RIGHT: begin
          pos_x_d = (right_v > 21'(xmax)) ? 16'(xmax) : right_v[15:0];
        end
        attc_pkg::FIN_LEFT: begin
          pos_x_d = (20'(pos_x_q) > n_w) ? pos_x_q - n_w[15:0] : '0;
        end
        attc_pkg::FIN_INS: begin
          cmd  = attc_pkg::CMD_INSERT;
          cx   = pos_x_q;
          cy   = pos_y_q;
          camt = (n_w > 20'(attc_pkg::ARG_MAX)) ? attc_pkg::ARG_MAX : n_w[15:0];
        end
        attc_pkg::FIN_J: begin
          cmd  = attc_pkg::CMD_SCROLL;
          camt = (page_v > 29'(sh)) ? 16'(sh) : page_v[15:0];
        end
        attc_pkg::FIN_K: begin
          cmd  = attc_pkg::CMD_CLEAR;
          cx   = pos_x_q;
          cy   = pos_y_q;
          camt = line_left;
        end
        attc_pkg::FIN_H: begin
          pos_x_d = arg_cur_q;
          pos_y_d = arg_prev_q;
        end
        attc_pkg::FIN_SAVE: begin
          saved_x_d = pos_x_q;
          saved_y_d = pos_y_q;
        end
        attc_pkg::FIN_REST: begin
          pos_x_d = saved_x_q;
          pos_y_d = saved_y_q;
        end
        attc_pkg::FIN_HIDE: begin
          cur_low_d  = '0;
          cur_high_d = '0;
        end
        attc_pkg::FIN_SHAPE: begin
          cur_low_d  = attc_pkg::clamp_rows(arg_prev_q);
          cur_high_d = (arg_cur_q != '0) ? attc_pkg::clamp_rows(arg_cur_q)
                                         : attc_pkg::CURSOR_HI_DFLT;
        end
        default: begin
        end
      endcase
    end
  end

  // state update, one character per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      saved_x_q  <= '0;
      saved_y_q  <= '0;
      attr_q     <= attc_pkg::ATTR_RESET;
      cur_low_q  <= '0;
      cur_high_q <= attc_pkg::CURSOR_HI_DFLT;
      mode_q     <= attc_pkg::MODE_TEXT;
      arg_cur_q  <= '0;
      arg_prev_q <= '0;
    end else if (step_i) begin
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      saved_x_q  <= saved_x_d;
      saved_y_q  <= saved_y_d;
      attr_q     <= attr_d;
      cur_low_q  <= cur_low_d;
      cur_high_q <= cur_high_d;
      mode_q     <= mode_d;
      arg_cur_q  <= arg_cur_d;
      arg_prev_q <= arg_prev_d;
    end
  end

  // result item from the post-step state
  always_comb begin
    result_o.command        = cmd;
    result_o.cmd_x          = cx;
    result_o.cmd_y          = cy;
    result_o.cmd_amount     = camt;
    result_o.glyph_code     = gcode;
    result_o.glyph_attr     = attr_d;
    result_o.cursor_x       = pos_x_d;
    result_o.cursor_y       = pos_y_d;
    result_o.cursor_top_row = attc_pkg::CURSOR_ROWS - cur_high_d;
    result_o.cursor_end_row = attc_pkg::CURSOR_ROWS - cur_low_d;
  end

endmodule

// ----- rtl/core/ansi_text_terminal_controller.sv -----
// top level: input register, terminal step core, output register and apb config
// path: a character is held in the input register, stepped by the core, and its command is held in the output register
// throughput: one character per cycle while commands are taken, with state fed back through one step of logic
// while a command waits on the output one more character is held, then input stalls
// reset: asynchronous active low, cursor, attribute and parser return to their
// initial values and the screen comes up as 640 by 480 pixels
module ansi_text_terminal_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  attc_char_if.sink    char_i,
  attc_cmd_if.source   cmd_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  attc_pkg::cfg_t    cfg;
  attc_pkg::result_t step_res;
  attc_pkg::result_t out_q;
  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_char_q;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              step;
  logic              in_accept;

  // config registers
  attc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake between input register and output register
  assign out_free     = !out_valid_q || cmd_o.ready;
  assign step         = in_valid_q && out_free;
  assign char_i.ready = !in_valid_q || out_free;
  assign in_accept    = char_i.valid && char_i.ready;
  assign in_valid_d   = in_accept || (in_valid_q && !step);
  assign out_valid_d  = step || (out_valid_q && !cmd_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input item register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_char_q <= char_i.char_code;
    end
  end

  // step core
  attc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_code_i (in_char_q),
    .cfg_i       (cfg),
    .result_o    (step_res)
  );

  // result item register
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= step_res;
    end
  end

  assign cmd_o.valid          = out_valid_q;
  assign cmd_o.command        = out_q.command;
  assign cmd_o.cmd_x          = out_q.cmd_x;
  assign cmd_o.cmd_y          = out_q.cmd_y;
  assign cmd_o.cmd_amount     = out_q.cmd_amount;
  assign cmd_o.glyph_code     = out_q.glyph_code;
  assign cmd_o.glyph_attr     = out_q.glyph_attr;
  assign cmd_o.cursor_x       = out_q.cursor_x;
  assign cmd_o.cursor_y       = out_q.cursor_y;
  assign cmd_o.cursor_top_row = out_q.cursor_top_row;
  assign cmd_o.cursor_end_row = out_q.cursor_end_row;

endmodule

// ----- tb/tb_ansi_text_terminal_controller.sv -----
// testbench of the ansi text terminal controller: byte stream driver, predictor and command checker
module tb_ansi_text_terminal_controller;
  import attc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;

  // characters used by the stimulus beyond the package set
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_TOP = 8'hff;

  // sgr colour codes
  localparam int unsigned SGR_RESET     = 0;
  localparam int unsigned SGR_BOLD      = 1;
  localparam int unsigned SGR_DIM       = 2;
  localparam int unsigned SGR_UNDERLINE = 4;
  localparam int unsigned SGR_BLINK     = 5;
  localparam int unsigned SGR_INVERSE   = 7;
  localparam int unsigned SGR_CONCEAL   = 8;
  localparam int unsigned SGR_FG_BASE   = 30;
  localparam int unsigned SGR_BG_BASE   = 40;

  // attribute bits touched by the colour codes
  localparam int unsigned ATTR_PLAIN   = 32'h00007;
  localparam int unsigned ATTR_BOLD    = 32'h00008;
  localparam int unsigned ATTR_DIM     = 32'h00800;
  localparam int unsigned ATTR_UL      = 32'h10000;
  localparam int unsigned ATTR_BLINK   = 32'h20000;
  localparam int unsigned ATTR_COLOURS = 32'h0ffff;
  localparam int unsigned ATTR_ALL     = 32'h3ffff;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  attc_char_if char_if ();
  attc_cmd_if  cmd_if ();

  ansi_text_terminal_controller u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .cmd_o   (cmd_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // stimulus and expectation stores
  logic [7:0]  char_pending_q[$];
  result_t     cmd_expected_q[$];
  logic        char_taken = 1'b0;
  int unsigned chars_queued = 0;
  int unsigned chars_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned screens_tried = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;

  // terminal state as the predictor sees it
  int unsigned scr_w, scr_h;
  int unsigned cur_x, cur_y, mark_x, mark_y;
  int unsigned attr_now, shape_lo, shape_hi;
  int unsigned num_now, num_prev;
  logic [1:0]  esc_state;

  int unsigned sgr_list[7] = '{SGR_RESET, SGR_BOLD, SGR_DIM, SGR_UNDERLINE, SGR_BLINK,
                               SGR_INVERSE, SGR_CONCEAL};
  logic [7:0]  csi_finals[13] = '{FIN_M, FIN_UP, FIN_DOWN, FIN_RIGHT, FIN_LEFT, FIN_INS,
                                  FIN_J, FIN_K, FIN_H, FIN_SAVE, FIN_REST, FIN_HIDE,
                                  FIN_SHAPE};

  function automatic int unsigned col_limit();
    return (scr_w > GLYPH_WIDTH) ? scr_w - GLYPH_WIDTH : 0;
  endfunction

  function automatic int unsigned row_limit();
    return (scr_h > GLYPH_HEIGHT) ? scr_h - GLYPH_HEIGHT : 0;
  endfunction

  function automatic int unsigned row_sat(input int unsigned v);
    return (v > 32'(CURSOR_ROWS)) ? 32'(CURSOR_ROWS) : v;
  endfunction

  // one colour code applied to the attribute
  function automatic void apply_sgr(input int unsigned code);
    case (code)
      SGR_RESET:     attr_now = ATTR_PLAIN;
      SGR_BOLD:      attr_now = attr_now | ATTR_BOLD;
      SGR_DIM:       attr_now = attr_now | ATTR_DIM;
      SGR_UNDERLINE: attr_now = attr_now | ATTR_UL;
      SGR_BLINK:     attr_now = attr_now | ATTR_BLINK;
      SGR_INVERSE:   attr_now = attr_now ^ ATTR_COLOURS;
      SGR_CONCEAL:   attr_now = attr_now & ATTR_COLOURS;
      default: begin
        if (code >= SGR_FG_BASE && code < SGR_FG_BASE + 8) begin
          attr_now = (attr_now & ~32'hff) | (code - SGR_FG_BASE);
        end else if (code >= SGR_BG_BASE && code < SGR_BG_BASE + 8) begin
          attr_now = (attr_now & ~32'hff00) | ((code - SGR_BG_BASE) << 8);
        end
        attr_now = attr_now & ATTR_ALL;
      end
    endcase
  endfunction

  // byte in plain text: newline, backspace, printable glyph, else nothing
  function automatic void plain_char(input logic [7:0] ch, inout result_t r);
    int unsigned lim, nxt;
    if (ch == CH_LF) begin
      lim = row_limit();
      nxt = cur_y + GLYPH_HEIGHT;
      cur_x = 0;
      if (nxt > lim) begin
        nxt = nxt - lim;
        if (nxt > scr_h) nxt = scr_h;
        r.command = CMD_SCROLL;
        r.cmd_amount = nxt[15:0];
        cur_y = lim;
      end else begin
        cur_y = nxt;
      end
    end else if (ch == CH_BS) begin
      if (cur_x >= GLYPH_WIDTH) begin
        lim = col_limit();
        r.command = CMD_DELETE;
        r.cmd_x = cur_x[15:0];
        r.cmd_y = cur_y[15:0];
        nxt = (lim > cur_x) ? lim - cur_x : 0;
        r.cmd_amount = nxt[15:0];
        cur_x = cur_x - GLYPH_WIDTH;
      end
    end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
      r.command = CMD_GLYPH;
      r.cmd_x = cur_x[15:0];
      r.cmd_y = cur_y[15:0];
      r.glyph_code = ch;
      cur_x = cur_x + GLYPH_WIDTH;
      if (cur_x > ARG_MAX) cur_x = ARG_MAX;
    end
  endfunction

  // final byte of an escape sequence
  function automatic void csi_final(input logic [7:0] ch, inout result_t r);
    int unsigned n, xlim, ylim, v;
    n = (num_now != 0) ? num_now : 1;
    xlim = col_limit();
    ylim = row_limit();
    case (ch)
      FIN_M: begin
        if (num_prev != 0) apply_sgr(num_prev);
        apply_sgr(num_now);
      end
      FIN_UP: begin
        v = n * GLYPH_HEIGHT;
        cur_y = (cur_y > v) ? cur_y - v : 0;
      end
      FIN_DOWN: begin
        v = cur_y + n * GLYPH_HEIGHT;
        cur_y = (v > ylim) ? ylim : v;
      end
      FIN_RIGHT: begin
        v = cur_x + n * GLYPH_WIDTH;
        cur_x = (v > xlim) ? xlim : v;
      end
      FIN_LEFT: begin
        v = n * GLYPH_WIDTH;
        cur_x = (cur_x > v) ? cur_x - v : 0;
      end
      FIN_INS: begin
        v = n * GLYPH_WIDTH;
        if (v > ARG_MAX) v = ARG_MAX;
        r.command = CMD_INSERT;
        r.cmd_x = cur_x[15:0];
        r.cmd_y = cur_y[15:0];
        r.cmd_amount = v[15:0];
      end
      FIN_J: begin
        v = n * ylim;
        if (v > scr_h) v = scr_h;
        r.command = CMD_SCROLL;
        r.cmd_amount = v[15:0];
      end
      FIN_K: begin
        v = (xlim > cur_x) ? xlim - cur_x : 0;
        r.command = CMD_CLEAR;
        r.cmd_x = cur_x[15:0];
        r.cmd_y = cur_y[15:0];
        r.cmd_amount = v[15:0];
      end
      FIN_H: begin
        cur_x = num_now;
        cur_y = num_prev;
      end
      FIN_SAVE: begin
        mark_x = cur_x;
        mark_y = cur_y;
      end
      FIN_REST: begin
        cur_x = mark_x;
        cur_y = mark_y;
      end
      FIN_HIDE: begin
        shape_lo = 0;
        shape_hi = 0;
      end
      FIN_SHAPE: begin
        shape_lo = row_sat(num_prev);
        shape_hi = (num_now != 0) ? row_sat(num_now) : 32'(CURSOR_HI_DFLT);
      end
      default: ;
    endcase
  endfunction

  // expected command for one accepted character, advancing the terminal state
  function automatic result_t terminal_step(input logic [7:0] ch);
    result_t     r;
    int unsigned v;
    r = '0;
    if (esc_state == MODE_CSI) begin
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        v = num_now * 10 + (ch - CH_ZERO);
        num_now = (v > ARG_MAX) ? ARG_MAX : v;
      end else if (ch == CH_SEMI) begin
        num_prev = num_now;
        num_now = 0;
      end else begin
        csi_final(ch, r);
        esc_state = MODE_TEXT;
      end
    end else if (esc_state == MODE_ESC) begin
      if (ch == CH_LBRACK) begin
        esc_state = MODE_CSI;
        num_now = 0;
        num_prev = 0;
      end else if (ch != CH_ESC) begin
        esc_state = MODE_TEXT;
        plain_char(ch, r);
      end
    end else begin
      if (ch == CH_ESC) esc_state = MODE_ESC;
      else plain_char(ch, r);
    end
    r.glyph_attr = attr_now[17:0];
    r.cursor_x = cur_x[15:0];
    r.cursor_y = cur_y[15:0];
    r.cursor_top_row = CURSOR_ROWS - shape_hi[4:0];
    r.cursor_end_row = CURSOR_ROWS - shape_lo[4:0];
    return r;
  endfunction

  function automatic string fmt_cmd(input result_t r);
    return $sformatf("cmd=%0d at %0d,%0d amt=%0d code=%02h attr=%05h cursor=%0d,%0d rows=%0d..%0d",
                     r.command, r.cmd_x, r.cmd_y, r.cmd_amount, r.glyph_code, r.glyph_attr,
                     r.cursor_x, r.cursor_y, r.cursor_top_row, r.cursor_end_row);
  endfunction

  // prediction on each accepted item, checking of each returned command
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      char_taken <= char_if.valid && char_if.ready;
      if (char_if.valid && char_if.ready) begin
        chars_accepted++;
        cmd_expected_q.push_back(terminal_step(char_if.char_code));
      end
      if (cmd_if.valid && cmd_if.ready) begin
        results_checked++;
        got = '{command: cmd_if.command, cmd_x: cmd_if.cmd_x, cmd_y: cmd_if.cmd_y,
                cmd_amount: cmd_if.cmd_amount, glyph_code: cmd_if.glyph_code,
                glyph_attr: cmd_if.glyph_attr, cursor_x: cmd_if.cursor_x,
                cursor_y: cmd_if.cursor_y, cursor_top_row: cmd_if.cursor_top_row,
                cursor_end_row: cmd_if.cursor_end_row};
        if (cmd_expected_q.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("command %0d arrived with none pending: %s", results_checked, fmt_cmd(got));
          mismatch_count++;
        end else begin
          want = cmd_expected_q.pop_front();
          if (got !== want) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("command %0d mismatch, expected %s", results_checked, fmt_cmd(want));
              $display("  actual   %s", fmt_cmd(got));
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  // character driver: next pending item once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!char_if.valid || char_taken)) begin
      if (char_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        char_if.valid <= 1'b1;
        char_if.char_code <= char_pending_q.pop_front();
      end else begin
        char_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(negedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req) hold_left <= HOLD_CYCLES;
  end

  // command receiver backpressure
  always @(negedge clk_i) begin
    if (rst_ni) cmd_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands still pending", cycle_count,
               cmd_expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] ch);
    char_pending_q.push_back(ch);
    chars_queued++;
  endtask

  task automatic push_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) push_byte(CH_ZERO);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic csi_seq(input string args, input logic [7:0] fin);
    push_byte(CH_ESC);
    push_byte(CH_LBRACK);
    for (int i = 0; i < args.len(); i++) push_byte(args[i]);
    push_byte(fin);
  endtask

  function automatic int unsigned pick_number();
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2, 3: return $urandom_range(1, 9);
      4, 5:    return $urandom_range(10, 99);
      6:       return $urandom_range(100, 999);
      7, 8:    return $urandom_range(1000, 65535);
      default: return $urandom_range(65536, 9999999);
    endcase
  endfunction

  function automatic int unsigned pick_colour();
    case ($urandom_range(0, 15))
      8, 9, 10:  return SGR_FG_BASE + $urandom_range(0, 7);
      11, 12, 13: return SGR_BG_BASE + $urandom_range(0, 7);
      14:        return $urandom_range(0, 99);
      15:        return pick_number();
      default:   return sgr_list[$urandom_range(0, 6)];
    endcase
  endfunction

  // well-formed escape sequence with random arguments
  task automatic push_csi();
    logic [7:0] fin;
    fin = csi_finals[$urandom_range(0, 12)];
    push_byte(CH_ESC);
    push_byte(CH_LBRACK);
    case (fin)
      FIN_M: begin
        if ($urandom_range(0, 2) == 0) begin
          push_number(pick_colour());
          push_byte(CH_SEMI);
        end
        if ($urandom_range(0, 5) != 0) push_number(pick_colour());
      end
      FIN_H: begin
        if ($urandom_range(0, 7) == 0) begin
          push_number($urandom_range(0, 65535));
          push_byte(CH_SEMI);
          push_number($urandom_range(0, 65535));
        end else if ($urandom_range(0, 5) != 0) begin
          push_number($urandom_range(0, row_limit()));
          push_byte(CH_SEMI);
          push_number($urandom_range(0, col_limit()));
        end
      end
      FIN_SHAPE: begin
        if ($urandom_range(0, 1) == 0) begin
          push_number($urandom_range(0, 20));
          push_byte(CH_SEMI);
        end
        if ($urandom_range(0, 3) != 0) push_number($urandom_range(0, 20));
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          push_number(pick_number());
          push_byte(CH_SEMI);
        end
        if ($urandom_range(0, 2) == 0) push_number(pick_number());
        else if ($urandom_range(0, 1) == 0) push_number($urandom_range(1, 4));
      end
    endcase
    push_byte(fin);
  endtask

  // mostly text and well-formed sequences, some noise and broken sequences
  task automatic gen_random(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    target = chars_queued + count;
    while (chars_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
      end else if (pick < 36) begin
        push_byte(CH_LF);
      end else if (pick < 44) begin
        push_byte(CH_BS);
      end else if (pick < 84) begin
        push_csi();
      end else if (pick < 91) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        push_byte(CH_ESC);
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(CH_ESC);
        push_byte(CH_LBRACK);
        if ($urandom_range(0, 1) == 0) push_number(pick_number());
        push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // apb write: setup then access, register taken when pready is high
  task automatic write_reg(input logic idx, input int unsigned value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_SCREEN_WIDTH) scr_w = value & 32'h1fff;
    else scr_h = value & 32'h1fff;
  endtask

  task automatic set_screen(input int unsigned w, input int unsigned h);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    screens_tried++;
  endtask

  task automatic wait_drained();
    while (char_pending_q.size() != 0 || char_if.valid || cmd_expected_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned idle,
                           input int unsigned stall, input int unsigned count);
    set_screen(w, h);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    gen_random(count);
    wait_drained();
  endtask

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    char_if.valid = 1'b0;
    char_if.char_code = '0;
    cmd_if.ready = 1'b0;

    // predictor state after reset
    scr_w = WIDTH_RESET;
    scr_h = HEIGHT_RESET;
    cur_x = 0;
    cur_y = 0;
    mark_x = 0;
    mark_y = 0;
    attr_now = ATTR_RESET;
    shape_lo = 0;
    shape_hi = CURSOR_HI_DFLT;
    esc_state = MODE_TEXT;
    num_now = 0;
    num_prev = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: edges of text handling, every final, lone and nested escapes
    set_screen(WIDTH_RESET, HEIGHT_RESET);
    push_byte(CH_SPACE);
    push_byte(CH_TILDE);
    push_byte(CH_BS);
    push_byte(CH_BS);
    push_byte(CH_BS);
    push_byte(CH_LF);
    push_byte(CH_TOP);
    push_byte(CH_NUL);
    push_byte(CH_DEL);
    push_byte(CH_ESC);
    push_byte("Q");
    push_byte(CH_ESC);
    csi_seq("70000;41", FIN_M);
    csi_seq("9;2", FIN_SHAPE);
    csi_seq("", FIN_SAVE);
    csi_seq("3", FIN_DOWN);
    csi_seq("2", FIN_RIGHT);
    csi_seq("", FIN_UP);
    csi_seq("", FIN_LEFT);
    csi_seq("9999", FIN_INS);
    csi_seq("", FIN_K);
    csi_seq("", FIN_REST);
    csi_seq("2", FIN_J);
    csi_seq("", FIN_HIDE);
    csi_seq("20;30", FIN_SHAPE);
    csi_seq("7", FIN_M);
    csi_seq("", "x");
    csi_seq("", CH_ESC);
    csi_seq("", CH_NUL);
    csi_seq("9999", FIN_RIGHT);
    csi_seq("65535;65530", FIN_H);
    push_byte("a");
    push_byte("b");
    push_byte(CH_LF);
    csi_seq("", FIN_H);
    wait_drained();

    // random phases over idling mixes and screen sizes
    run_phase(16, 32, 0, 0, 160);
    run_phase(4096, 4096, 45, 0, 160);
    run_phase($urandom_range(16, 4096), $urandom_range(32, 4096), 0, 45, 160);
    run_phase(80, 48, 21, 21, 160);

    // receiver holds off while the sender keeps offering, then a full drain pause
    set_screen(4096, 32);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    hold_req = 1'b1;
    wait (hold_left != 0);
    hold_req = 1'b0;
    gen_random(60);
    wait_drained();
    gen_random(40);
    wait_drained();

    repeat (8) @(posedge clk_i);
    $display("%0d characters accepted, %0d commands checked over %0d screen sizes",
             chars_accepted, results_checked, screens_tried);
    $display("%0d mismatches, %0d commands never returned", mismatch_count,
             cmd_expected_q.size());
    if (mismatch_count == 0 && cmd_expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
